@@ src/sas_pkg.sv @@
// Shared types and constants for the stable ascending sorter.
// Used by the channel interfaces, the cell, the controller and the top level.
package sas_pkg;

    localparam int SAS_DATA_W = 32;
    localparam int SAS_DEPTH  = 64;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } t_cell_op;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                         valid;
        logic signed [SAS_DATA_W-1:0] value;
    } t_cell;

    // command broadcast from the controller to every cell
    typedef struct packed {
        t_cell_op                     op;
        logic signed [SAS_DATA_W-1:0] value;
    } t_cell_ctrl;

    // occupancy seen by the controller at the ends of the chain
    typedef struct packed {
        logic head_valid;
        logic second_valid;
        logic tail_valid;
    } t_chain_status;

endpackage

@@ src/sas_if.sv @@
// Valid/ready channel interfaces for the sorter's input items and result items.
// Depends on sas_pkg for the data width.
interface sas_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [sas_pkg::SAS_DATA_W-1:0] value;
    logic                                  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface sas_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [sas_pkg::SAS_DATA_W-1:0] sorted_value;
    logic                                  final_res;
    logic                                  overflow;

    modport source (output valid, output sorted_value, output final_res, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input final_res, input overflow,
                    output ready);
endinterface

@@ src/sas_cell.sv @@
// One slot of the insertion chain: holds a value, compares it to the broadcast one.
// Depends on sas_pkg for the cell and command types.
module sas_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sas_pkg::t_cell_ctrl i_ctrl,
    input  sas_pkg::t_cell      i_prev,
    input  logic                i_prev_take,
    input  sas_pkg::t_cell      i_next,
    output sas_pkg::t_cell      o_cell,
    output logic                o_take
);
    import sas_pkg::*;

    logic                         r_valid;
    logic signed [SAS_DATA_W-1:0] r_value;
    logic                         n_valid;
    logic signed [SAS_DATA_W-1:0] n_value;

    // empty slots and strictly greater values give way, so equal values keep order
    assign o_take = !r_valid || (r_value > i_ctrl.value);
    assign o_cell = '{valid: r_valid, value: r_value};

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        case (i_ctrl.op)
            OP_INSERT: begin
                if (i_prev_take) begin
                    n_valid = i_prev.valid;
                    n_value = i_prev.value;
                end else if (o_take) begin
                    n_valid = 1'b1;
                    n_value = i_ctrl.value;
                end
            end
            OP_SHIFT: begin
                n_valid = i_next.valid;
                n_value = i_next.value;
            end
            default: begin
                n_valid = r_valid;
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

@@ src/sas_ctrl.sv @@
// Load/emit sequencer: issues insert and shift commands to the cell chain.
// Depends on sas_pkg for the state, command and status types.
module sas_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic signed [sas_pkg::SAS_DATA_W-1:0] i_in_value,
    input  logic                   i_in_last,
    input  logic                   i_out_ready,
    input  sas_pkg::t_chain_status i_status,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output logic                   o_final_res,
    output logic                   o_overflow,
    output sas_pkg::t_cell_ctrl    o_ctrl
);
    import sas_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_dropped;
    logic   n_dropped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dropped <= n_dropped;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_dropped    = r_dropped;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_ctrl.op    = OP_HOLD;
        o_ctrl.value = i_in_value;
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    // chain full: drop the value and remember it
                    if (i_status.tail_valid) begin
                        n_dropped = 1'b1;
                    end else begin
                        o_ctrl.op = OP_INSERT;
                    end
                    if (i_in_last) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                o_out_valid = i_status.head_valid;
                if (i_out_ready && i_status.head_valid) begin
                    o_ctrl.op = OP_SHIFT;
                    if (!i_status.second_valid) begin
                        n_state   = ST_LOAD;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_final_res = !i_status.second_valid;
    assign o_overflow  = r_dropped;

endmodule

@@ src/stable_ascending_sorter.sv @@
// Stable ascending sorter: a chain of DEPTH insertion cells and its sequencer.
// Depends on sas_pkg, sas_if, sas_cell and sas_ctrl.
//
// Usage: send a list of signed 32-bit values on i_in, one per transfer, with
// last set on the final one. Each accepted value is placed into the chain in
// the cycle of its transfer, one item per cycle, equal values in arrival order.
// Values beyond DEPTH are dropped and overflow is set on every result of that list.
// The cycle after the last transfer, the sorted list starts on o_out, smallest
// first, one result per cycle while o_out.ready is high; final_res marks the
// last one. The chain shifts one slot toward its head per result transfer.
// i_in.ready stays low during emission and returns high the cycle after the
// final transfer. When the receiver stalls, the head result holds and the
// chain holds with it. Reset empties the chain, clears the overflow flag and
// starts in loading.
module stable_ascending_sorter #(
    parameter int DEPTH = sas_pkg::SAS_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sas_in_if.sink    i_in,
    sas_out_if.source o_out
);
    import sas_pkg::*;

    t_cell         w_cell [DEPTH];
    logic          w_take [DEPTH];
    t_cell_ctrl    w_ctrl;
    t_chain_status w_status;

    assign w_status.head_valid   = w_cell[0].valid;
    assign w_status.second_valid = w_cell[1].valid;
    assign w_status.tail_valid   = w_cell[DEPTH-1].valid;

    sas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_value  (i_in.value),
        .i_in_last   (i_in.last),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_final_res (o_out.final_res),
        .o_overflow  (o_out.overflow),
        .o_ctrl      (w_ctrl)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell w_prev;
        logic  w_prev_take;
        t_cell w_next;

        if (g == 0) begin : g_head
            assign w_prev      = '0;
            assign w_prev_take = 1'b0;
        end else begin : g_body
            assign w_prev      = w_cell[g-1];
            assign w_prev_take = w_take[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_cell[g+1];
        end

        sas_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_prev      (w_prev),
            .i_prev_take (w_prev_take),
            .i_next      (w_next),
            .o_cell      (w_cell[g]),
            .o_take      (w_take[g])
        );
    end

    assign o_out.sorted_value = w_cell[0].value;

endmodule

@@ verif/stable_ascending_sorter_test.sv @@
// Self-checking testbench for the stable ascending sorter: drives lists of values,
// predicts the sorted output with its own insertion model and checks every result.
// Depends on sas_pkg, the sas_in_if / sas_out_if channels and stable_ascending_sorter.
`timescale 1ns / 100ps

module stable_ascending_sorter_test;
    import sas_pkg::*;

    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 160;
    localparam int QUIET_AFTER  = 135;
    localparam int MIN_LISTS    = 5;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE       = 20;

    // Keeps its own copy of the sorted list and the queue of results still due.
    class sort_scoreboard;
        typedef struct {
            logic signed [SAS_DATA_W-1:0] sorted_value;
            logic                         final_res;
            logic                         overflow;
        } t_sorted_item;

        logic signed [SAS_DATA_W-1:0] held[SAS_DEPTH];
        int                           held_count;
        bit                           dropped;
        t_sorted_item                 due_q[$];
        int                           mismatches;
        int                           results_seen;

        function new();
            held_count   = 0;
            dropped      = 0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // Insert after every equal value; on the last transfer queue the whole list.
        function void note_input(logic signed [SAS_DATA_W-1:0] value, logic last);
            int           pos;
            t_sorted_item item;
            if (held_count >= SAS_DEPTH) begin
                dropped = 1;
            end else begin
                pos = held_count;
                while (pos > 0 && held[pos-1] > value) begin
                    held[pos] = held[pos-1];
                    pos--;
                end
                held[pos] = value;
                held_count++;
            end
            if (last) begin
                for (int k = 0; k < held_count; k++) begin
                    item.sorted_value = held[k];
                    item.final_res    = (k == held_count - 1);
                    item.overflow     = dropped;
                    due_q = {due_q, item};
                end
                held_count = 0;
                dropped    = 0;
            end
        endfunction

        task report(string what);
            $display("%0t ns: mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(logic signed [SAS_DATA_W-1:0] sorted_value, logic final_res,
                          logic overflow);
            t_sorted_item want;
            results_seen++;
            if (due_q.size() == 0) begin
                report($sformatf("unexpected result value %0d", sorted_value));
            end else begin
                want = due_q.pop_front();
                if (sorted_value !== want.sorted_value)
                    report($sformatf("sorted_value %0d, expected %0d",
                                     sorted_value, want.sorted_value));
                if (final_res !== want.final_res)
                    report($sformatf("final_res %b, expected %b", final_res, want.final_res));
                if (overflow !== want.overflow)
                    report($sformatf("overflow %b, expected %b", overflow, want.overflow));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    sas_in_if  in_ch();
    sas_out_if out_ch();

    stable_ascending_sorter #(.DEPTH(SAS_DEPTH)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    sort_scoreboard sb = new();

    bit idling_on     = 1;
    bit long_hold_req = 0;
    int items_sent    = 0;
    int lists_sent    = 0;
    int overflow_runs = 0;

    logic signed [SAS_DATA_W-1:0] list_q[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("stable_ascending_sorter test failed");
        $finish;
    end

    // Sample both channels on the edge; a transfer is valid and ready at that edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.sorted_value, out_ch.final_res, out_ch.overflow);
            if (in_ch.valid && in_ch.ready)
                sb.note_input(in_ch.value, in_ch.last);
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (long_hold_req && out_ch.valid) begin
                long_hold_req = 0;
                out_ch.ready <= 1'b0;
                hold_left = LONG_HOLD - 1;
            end else if (idling_on && $urandom_range(0, 6) == 0) begin
                out_ch.ready <= 1'b0;
                hold_left = $urandom_range(1, 14) - 1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic signed [SAS_DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(SAS_DATA_W-1){1'b0}}};
            1:       return {1'b0, {(SAS_DATA_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            4, 5:    return $signed($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    // Present one item and hold it until the transfer happens.
    task send_item(logic signed [SAS_DATA_W-1:0] value, logic last);
        in_ch.valid <= 1'b1;
        in_ch.value <= value;
        in_ch.last  <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task maybe_gap();
        if (idling_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // Send list_q as one list, last set on its final entry.
    task send_queued();
        maybe_gap();
        for (int k = 0; k < list_q.size(); k++) begin
            send_item(list_q[k], k == list_q.size() - 1);
            maybe_gap();
        end
        lists_sent++;
        if (list_q.size() > SAS_DEPTH) overflow_runs++;
    endtask

    task fill_random(int len);
        list_q = {};
        repeat (len) list_q = {list_q, pick_value()};
    endtask

    initial begin
        logic signed [SAS_DATA_W-1:0] vmin;
        logic signed [SAS_DATA_W-1:0] vmax;
        int                           list_idx;
        int                           rand_items;
        int                           len;
        int                           waited;

        vmin = {1'b1, {(SAS_DATA_W-1){1'b0}}};
        vmax = {1'b0, {(SAS_DATA_W-1){1'b1}}};

        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        in_ch.last  <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed lists: single item, extremes with duplicates, all equal,
        // descending and ascending order
        list_q = {vmax};
        send_queued();
        list_q = {32'sd5, -32'sd3, 32'sd5, vmin, vmax, 32'sd5, -32'sd1, 32'sd0};
        send_queued();
        list_q = {32'sd7, 32'sd7, 32'sd7};
        send_queued();
        list_q = {32'sd3, 32'sd2, 32'sd1, 32'sd0, -32'sd1, -32'sd2};
        send_queued();
        list_q = {vmin, -32'sd1, 32'sd0, 32'sd1, vmax};
        send_queued();

        list_idx   = 0;
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS || list_idx < MIN_LISTS) begin
            if (rand_items >= QUIET_AFTER) idling_on = 0;
            if (list_idx == 1) begin
                // full store; the receiver holds off while the next list waits
                len = SAS_DEPTH;
            end else if (list_idx == 3) begin
                // overflow: the extra items, last among them, are dropped
                len = SAS_DEPTH + 2;
            end else begin
                if (list_idx == 4) begin
                    in_ch.valid <= 1'b0;
                    @(posedge i_clk);
                    while (sb.pending() != 0) @(posedge i_clk);
                end
                len = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 8)
                                                  : $urandom_range(9, 24);
            end
            fill_random(len);
            send_queued();
            if (list_idx == 1) long_hold_req = 1;
            rand_items += len;
            list_idx++;
        end
        in_ch.valid <= 1'b0;
        @(posedge i_clk);

        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));

        $display("covered %0d lists, %0d items, %0d results, %0d overflowed lists",
                 lists_sent, items_sent, sb.results_seen, overflow_runs);
        $display("including a full store, a long receiver hold-off and an idle pause");
        if (sb.mismatches == 0) begin
            $display("stable_ascending_sorter test passed");
        end else begin
            $display("stable_ascending_sorter test failed");
        end
        $finish;
    end

endmodule
